[hw/rtl/genotype_probability_unpacker_core_assert.svh]
// Assertion macros for the unpacker core RTL
`ifndef GENOTYPE_PROBABILITY_UNPACKER_CORE_ASSERT_SVH
`define GENOTYPE_PROBABILITY_UNPACKER_CORE_ASSERT_SVH

// same-cycle implication
`define GPUNP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gpunp assertion failed");

// next-cycle implication
`define GPUNP_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gpunp assertion failed");

`endif

[hw/rtl/gpunp_pkg.sv]
package gpunp_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 4096;
   localparam int MAX_ALLELES         = 4;
   localparam int PLOIDY_CEILING      = 4;
   localparam int FRACTION_BITS       = 32;
   localparam int RESULT_CAP          = 64;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 13;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BITS_PER_VALUE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALLELE_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PHASED_MODE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLOIDY_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_COUNT   = 3'd4;

   localparam logic [1:0] ACT_PLOIDY = 2'd0;
   localparam logic [1:0] ACT_DATA   = 2'd1;
   localparam logic [1:0] ACT_FLUSH  = 2'd2;

   localparam logic [1:0] KIND_DECODED   = 2'd0;
   localparam logic [1:0] KIND_REMAINDER = 2'd1;
   localparam logic [1:0] KIND_MISSING   = 2'd2;
   localparam logic [1:0] KIND_PADDING   = 2'd3;

   typedef struct packed {
      logic [31:0] probability;
      logic [31:0] raw_value;
      logic [11:0] sample_index;
      logic [5:0]  slot_index;
      logic [1:0]  value_kind;
      logic        sum_overflow;
      logic        last_of_sample;
   } result_type;

   // C(a+p-1, a-1) for a in 2..4, p in 0..4
   function automatic logic [5:0] slot_count(input logic [2:0] a, input logic [2:0] p);
      logic [5:0] c;
      c = 6'd1;
      unique case (a)
         3'd3: begin
            unique case (p)
               3'd1: c = 6'd3;
               3'd2: c = 6'd6;
               3'd3: c = 6'd10;
               3'd4: c = 6'd15;
               default: c = 6'd1;
            endcase
         end
         3'd4: begin
            unique case (p)
               3'd1: c = 6'd4;
               3'd2: c = 6'd10;
               3'd3: c = 6'd20;
               3'd4: c = 6'd35;
               default: c = 6'd1;
            endcase
         end
         default: c = 6'(p) + 6'd1;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/gpunp_if.sv]
interface gpunp_req_if;
   import gpunp_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] byte_value;
   modport source (output valid, action, byte_value, input ready);
   modport sink (input valid, action, byte_value, output ready);
endinterface

interface gpunp_rsp_if;
   import gpunp_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] probability;
   logic [31:0] raw_value;
   logic [11:0] sample_index;
   logic [5:0]  slot_index;
   logic [1:0]  value_kind;
   logic        sum_overflow;
   logic        last_of_sample;
   logic        last_of_run;
   modport source (output valid, probability, raw_value, sample_index, slot_index,
                   value_kind, sum_overflow, last_of_sample, last_of_run, input ready);
   modport sink (input valid, probability, raw_value, sample_index, slot_index,
                 value_kind, sum_overflow, last_of_sample, last_of_run, output ready);
endinterface

[hw/rtl/gpunp_ram.sv]
module gpunp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                         write_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data <= mem_ff[read_address];
   end
endmodule

[hw/rtl/gpunp_frac.sv]
module gpunp_frac (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] raw_value,
   input  logic [5:0]  width_n,
   output logic        done,
   output logic [31:0] fraction
);
   import gpunp_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;

   // pattern doubles in length each pass: acc |= acc >> step
   assign done     = busy_ff && (step_ff >= 6'd32);
   assign fraction = acc_ff;

   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = raw_value << (6'd32 - width_n);
         step_in = width_n;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff >= 6'd32) begin
            busy_in = 1'b0;
         end else begin
            acc_in  = acc_ff | (acc_ff >> step_ff);
            step_in = step_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end
endmodule

[hw/rtl/genotype_probability_unpacker_core.sv]
// Ploidy requests: table write only, no result.
// Data/flush requests: one result per slot; decoded and remainder results wait for the
// shared shifter to build the fraction, padding and missing results do not.
// At most 64 results per request; the request port is held off until the last is queued.
// Synchronous active-high reset clears cursors and config; the ploidy table is not cleared.
module genotype_probability_unpacker_core #(
   parameter int MAX_SAMPLES = gpunp_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [gpunp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gpunp_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   gpunp_req_if.sink                              req_channel,
   gpunp_rsp_if.source                            rsp_channel
);
   import gpunp_pkg::*;
   `include "genotype_probability_unpacker_core_assert.svh"

   localparam int SW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam logic [31:0] MaxSamplesU = 32'(MAX_SAMPLES);

   typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_LOOK, ST_FRAC, ST_END} state_type;

   state_type   state_ff, state_in;
   logic [5:0]  cfg_bpv_ff, cfg_bpv_in;
   logic [2:0]  cfg_ac_ff, cfg_ac_in;
   logic        cfg_ph_ff, cfg_ph_in;
   logic [2:0]  cfg_pl_ff, cfg_pl_in;
   logic [12:0] cfg_sc_ff, cfg_sc_in;
   logic        flush_ff, flush_in;
   logic [6:0]  k_ff, k_in;
   logic [SW-1:0] wr_index_ff, wr_index_in;
   logic [SW-1:0] sample_ff, sample_in;
   logic [39:0] buffer_ff, buffer_in;
   logic [5:0]  held_ff, held_in;
   logic [5:0]  slot_ff, slot_in;
   logic [5:0]  vig_ff, vig_in;
   logic [2:0]  hap_ff, hap_in;
   logic [39:0] sum_ff, sum_in;
   result_type  res_ff, res_in;
   logic        has_res_ff, has_res_in;
   result_type  out_ff, out_in;
   logic        out_run_ff, out_run_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        ram_we;
   logic [7:0]  ram_q;
   logic        frac_start, frac_done;
   logic [31:0] frac_result;
   logic [31:0] cur_raw;

   logic [5:0]  n;
   logic [2:0]  a, lim, pl, groups;
   logic [5:0]  row, vals;
   logic [31:0] denom;
   logic        miss, in_group, decode, brk, stop, samples_done, is_last, sum_over;
   logic [31:0] dec_raw, rem_raw;

   gpunp_ram #(.WIDTH(8), .DEPTH(MAX_SAMPLES)) u_ploidy_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (wr_index_ff[AW-1:0]),
      .write_data    (req_channel.byte_value),
      .read_address  (sample_ff[AW-1:0]),
      .read_data     (ram_q)
   );

   gpunp_frac u_frac (
      .clock     (clock),
      .reset     (reset),
      .start     (frac_start),
      .raw_value (cur_raw),
      .width_n   (n),
      .done      (frac_done),
      .fraction  (frac_result)
   );

   assign req_channel.ready = (state_ff == ST_IDLE);
   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.probability    = out_ff.probability;
   assign rsp_channel.raw_value      = out_ff.raw_value;
   assign rsp_channel.sample_index   = out_ff.sample_index;
   assign rsp_channel.slot_index     = out_ff.slot_index;
   assign rsp_channel.value_kind     = out_ff.value_kind;
   assign rsp_channel.sum_overflow   = out_ff.sum_overflow;
   assign rsp_channel.last_of_sample = out_ff.last_of_sample;
   assign rsp_channel.last_of_run    = out_run_ff;

   // clamped configuration
   always_comb begin
      n   = (cfg_bpv_ff == 6'd0) ? 6'd1 : ((cfg_bpv_ff > 6'd32) ? 6'd32 : cfg_bpv_ff);
      a   = (cfg_ac_ff < 3'd2) ? 3'd2 :
            ((cfg_ac_ff > 3'(MAX_ALLELES)) ? 3'(MAX_ALLELES) : cfg_ac_ff);
      lim = (cfg_pl_ff < 3'd1) ? 3'd1 :
            ((cfg_pl_ff > 3'(PLOIDY_CEILING)) ? 3'(PLOIDY_CEILING) : cfg_pl_ff);
      row   = cfg_ph_ff ? (6'(lim) * 6'(a)) : slot_count(a, lim);
      denom = 32'((33'd1 << n) - 33'd1);
   end

   // per-slot decision
   always_comb begin
      miss     = ram_q[7];
      pl       = (ram_q[6:0] > 7'(lim)) ? lim : ram_q[2:0];
      groups   = cfg_ph_ff ? pl : 3'd1;
      vals     = cfg_ph_ff ? (6'(a) - 6'd1) : (slot_count(a, pl) - 6'd1);
      in_group = hap_ff < groups;
      decode   = in_group && (vig_ff < vals);
      brk      = decode && (held_ff < n) && !flush_ff;
      samples_done = (32'(sample_ff) >= 32'(cfg_sc_ff)) || (32'(sample_ff) >= MaxSamplesU);
      stop     = (k_ff == 7'(RESULT_CAP)) || samples_done || brk;
      is_last  = (7'(slot_ff) + 7'd1) >= 7'(row);
      dec_raw  = buffer_ff[31:0] & denom;
      sum_over = sum_ff > 40'(denom);
      rem_raw  = sum_over ? 32'd0 : (denom - sum_ff[31:0]);
      cur_raw  = in_group ? (decode ? dec_raw : rem_raw) : 32'd0;
   end

   always_comb begin
      state_in    = state_ff;
      cfg_bpv_in  = cfg_bpv_ff;
      cfg_ac_in   = cfg_ac_ff;
      cfg_ph_in   = cfg_ph_ff;
      cfg_pl_in   = cfg_pl_ff;
      cfg_sc_in   = cfg_sc_ff;
      flush_in    = flush_ff;
      k_in        = k_ff;
      wr_index_in = wr_index_ff;
      sample_in   = sample_ff;
      buffer_in   = buffer_ff;
      held_in     = held_ff;
      slot_in     = slot_ff;
      vig_in      = vig_ff;
      hap_in      = hap_ff;
      sum_in      = sum_ff;
      res_in      = res_ff;
      has_res_in  = has_res_ff;
      out_in      = out_ff;
      out_run_in  = out_run_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we      = 1'b0;
      frac_start  = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BITS_PER_VALUE: cfg_bpv_in = csr_write_data[5:0];
            CSR_ALLELE_COUNT:   cfg_ac_in  = csr_write_data[2:0];
            CSR_PHASED_MODE:    cfg_ph_in  = csr_write_data[0];
            CSR_PLOIDY_LIMIT:   cfg_pl_in  = csr_write_data[2:0];
            CSR_SAMPLE_COUNT:   cfg_sc_in  = csr_write_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_channel.valid) begin
               unique case (req_channel.action)
                  ACT_PLOIDY: begin
                     if (32'(wr_index_ff) < MaxSamplesU) begin
                        ram_we      = 1'b1;
                        wr_index_in = wr_index_ff + SW'(1);
                     end
                  end
                  ACT_DATA: begin
                     if (held_ff <= 6'd32) begin
                        buffer_in = buffer_ff | (40'(req_channel.byte_value) << held_ff);
                        held_in   = held_ff + 6'd8;
                     end
                     flush_in = 1'b0;
                     k_in     = 7'd0;
                     state_in = ST_FETCH;
                  end
                  ACT_FLUSH: begin
                     flush_in = 1'b1;
                     k_in     = 7'd0;
                     state_in = ST_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: state_in = ST_LOOK;
         ST_LOOK: begin
            if (stop) begin
               state_in = ST_END;
            end else if (!(has_res_ff && rsp_valid_ff)) begin
               if (has_res_ff) begin
                  out_in       = res_ff;
                  out_run_in   = 1'b0;
                  rsp_valid_in = 1'b1;
               end
               res_in.probability    = 32'd0;
               res_in.raw_value      = cur_raw;
               res_in.sample_index   = 12'(sample_ff);
               res_in.slot_index     = slot_ff;
               res_in.sum_overflow   = 1'b0;
               res_in.last_of_sample = is_last;
               res_in.value_kind     = KIND_PADDING;
               if (in_group) begin
                  if (decode) begin
                     buffer_in = buffer_ff >> n;
                     held_in   = (held_ff >= n) ? (held_ff - n) : 6'd0;
                     sum_in    = sum_ff + 40'(dec_raw);
                     vig_in    = vig_ff + 6'd1;
                     res_in.value_kind = KIND_DECODED;
                  end else begin
                     res_in.sum_overflow = sum_over;
                     res_in.value_kind   = KIND_REMAINDER;
                     sum_in = 40'd0;
                     vig_in = 6'd0;
                     hap_in = hap_ff + 3'd1;
                  end
               end
               if (miss) begin
                  res_in.value_kind   = KIND_MISSING;
                  res_in.raw_value    = 32'd0;
                  res_in.sum_overflow = 1'b0;
               end
               slot_in = slot_ff + 6'd1;
               if (is_last) begin
                  sample_in = sample_ff + SW'(1);
                  slot_in   = 6'd0;
                  vig_in    = 6'd0;
                  hap_in    = 3'd0;
                  sum_in    = 40'd0;
               end
               k_in = k_ff + 7'd1;
               if (in_group && !miss) begin
                  frac_start = 1'b1;
                  has_res_in = 1'b0;
                  state_in   = ST_FRAC;
               end else begin
                  has_res_in = 1'b1;
                  state_in   = ST_FETCH;
               end
            end
         end
         ST_FRAC: begin
            if (frac_done) begin
               res_in.probability = frac_result;
               has_res_in = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_END: begin
            if (!has_res_ff || !rsp_valid_ff) begin
               if (has_res_ff) begin
                  out_in       = res_ff;
                  out_run_in   = 1'b1;
                  rsp_valid_in = 1'b1;
                  has_res_in   = 1'b0;
               end
               if (flush_ff && samples_done) begin
                  wr_index_in = '0;
                  buffer_in   = 40'd0;
                  held_in     = 6'd0;
                  sample_in   = '0;
                  slot_in     = 6'd0;
                  vig_in      = 6'd0;
                  hap_in      = 3'd0;
                  sum_in      = 40'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_bpv_ff   <= 6'd8;
         cfg_ac_ff    <= 3'd2;
         cfg_ph_ff    <= 1'b0;
         cfg_pl_ff    <= 3'd2;
         cfg_sc_ff    <= 13'd1;
         flush_ff     <= 1'b0;
         k_ff         <= 7'd0;
         wr_index_ff  <= '0;
         sample_ff    <= '0;
         buffer_ff    <= 40'd0;
         held_ff      <= 6'd0;
         slot_ff      <= 6'd0;
         vig_ff       <= 6'd0;
         hap_ff       <= 3'd0;
         sum_ff       <= 40'd0;
         has_res_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_bpv_ff   <= cfg_bpv_in;
         cfg_ac_ff    <= cfg_ac_in;
         cfg_ph_ff    <= cfg_ph_in;
         cfg_pl_ff    <= cfg_pl_in;
         cfg_sc_ff    <= cfg_sc_in;
         flush_ff     <= flush_in;
         k_ff         <= k_in;
         wr_index_ff  <= wr_index_in;
         sample_ff    <= sample_in;
         buffer_ff    <= buffer_in;
         held_ff      <= held_in;
         slot_ff      <= slot_in;
         vig_ff       <= vig_in;
         hap_ff       <= hap_in;
         sum_ff       <= sum_in;
         has_res_ff   <= has_res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff     <= res_in;
      out_ff     <= out_in;
      out_run_ff <= out_run_in;
   end

   `GPUNP_ASSERT_IMP(a_result_cap, 1'b1, k_ff <= 7'(RESULT_CAP))
   `GPUNP_ASSERT_IMP(a_held_bound, 1'b1, held_ff <= 6'd40)
   `GPUNP_ASSERT_IMP(a_frac_in_state, frac_done, state_ff == ST_FRAC)
   `GPUNP_ASSERT_NXT(a_push_result, state_ff == ST_LOOK && !stop && has_res_ff && !rsp_valid_ff, rsp_valid_ff)
endmodule

[sim/genotype_probability_unpacker_core_checker.sv]
`timescale 1ns / 1ps

module genotype_probability_unpacker_core_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [gpunp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gpunp_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   gpunp_req_if                                  req_channel,
   gpunp_rsp_if                                  rsp_channel,
   output int unsigned                           error_count,
   output int unsigned                           pending_count
);
   import gpunp_pkg::*;

   typedef struct packed {
      result_type fields;
      logic       last_of_run;
   } unpacked_value_type;

   unpacked_value_type expected_values[$];

   logic [7:0]  ploidy_mem [MAX_SAMPLES_DEFAULT];
   int unsigned table_wr, held_bits, sample_cur, slot_cur, value_cur, hap_cur;
   logic [63:0] bit_store, sum_acc;
   logic [5:0]  cfg_bits;
   logic [2:0]  cfg_alleles;
   logic        cfg_phased;
   logic [2:0]  cfg_plimit;
   logic [12:0] cfg_samples;

   initial error_count = 0;

   function automatic int unsigned choose(input int unsigned nn, input int unsigned kk);
      int unsigned c;
      c = 1;
      for (int unsigned i = 1; i <= kk; i++) c = c * (nn - kk + i) / i;
      return c;
   endfunction

   // raw/(2^n-1) as a 32-bit fraction: the n-bit pattern repeated
   function automatic logic [31:0] fraction_of(input logic [63:0] raw, input int unsigned n);
      logic [31:0] acc;
      acc = '0;
      for (int unsigned i = 0; i < 32; i++) acc = {acc[30:0], raw[n - 1 - (i % n)]};
      return acc;
   endfunction

   function automatic void clear_cursors();
      table_wr   = 0;
      bit_store  = '0;
      held_bits  = 0;
      sample_cur = 0;
      slot_cur   = 0;
      value_cur  = 0;
      hap_cur    = 0;
      sum_acc    = '0;
   endfunction

   task automatic decode_request(input logic [1:0] act, input logic [7:0] b);
      int unsigned        n, a, lim, cnt, row, pl, groups, vals, k;
      logic [63:0]        denom, raw;
      logic [7:0]         pm;
      logic [1:0]         kind;
      logic               ovf, flush, last;
      unpacked_value_type v;
      if (act == ACT_PLOIDY) begin
         if (table_wr < MAX_SAMPLES_DEFAULT) begin
            ploidy_mem[table_wr] = b;
            table_wr++;
         end
         return;
      end
      if (act != ACT_DATA && act != ACT_FLUSH) return;
      if (act == ACT_DATA && held_bits <= 32) begin
         bit_store = bit_store | (64'(b) << held_bits);
         held_bits += 8;
      end
      flush = (act == ACT_FLUSH);
      n     = cfg_bits == 0 ? 1 : (cfg_bits > 32 ? 32 : cfg_bits);
      a     = cfg_alleles < 2 ? 2 : (cfg_alleles > MAX_ALLELES ? MAX_ALLELES : cfg_alleles);
      lim   = cfg_plimit < 1 ? 1 : (cfg_plimit > PLOIDY_CEILING ? PLOIDY_CEILING : cfg_plimit);
      cnt   = cfg_samples > MAX_SAMPLES_DEFAULT ? MAX_SAMPLES_DEFAULT : cfg_samples;
      row   = cfg_phased ? lim * a : choose(a + lim - 1, a - 1);
      denom = (64'd1 << n) - 64'd1;
      k     = 0;
      while (k < RESULT_CAP && sample_cur < cnt) begin
         pm     = ploidy_mem[sample_cur];
         pl     = pm[6:0] > lim ? lim : pm[6:0];
         groups = cfg_phased ? pl : 1;
         vals   = cfg_phased ? a - 1 : choose(a + pl - 1, a - 1) - 1;
         raw    = '0;
         ovf    = 1'b0;
         if (hap_cur < groups) begin
            if (value_cur < vals) begin
               if (held_bits < n && !flush) break;
               raw       = bit_store & denom;
               bit_store = bit_store >> n;
               held_bits = held_bits >= n ? held_bits - n : 0;
               sum_acc   = sum_acc + raw;
               value_cur++;
               kind      = KIND_DECODED;
            end else begin
               if (sum_acc > denom) begin
                  ovf = 1'b1;
               end else begin
                  raw = denom - sum_acc;
               end
               kind      = KIND_REMAINDER;
               sum_acc   = '0;
               value_cur = 0;
               hap_cur++;
            end
         end else begin
            kind = KIND_PADDING;
         end
         if (pm[7]) begin
            kind = KIND_MISSING;
            raw  = '0;
            ovf  = 1'b0;
         end
         last = slot_cur + 1 >= row;
         v.fields.probability    = (kind == KIND_DECODED || kind == KIND_REMAINDER) ?
                                   fraction_of(raw, n) : 32'd0;
         v.fields.raw_value      = raw[31:0];
         v.fields.sample_index   = sample_cur[11:0];
         v.fields.slot_index     = slot_cur[5:0];
         v.fields.value_kind     = kind;
         v.fields.sum_overflow   = ovf;
         v.fields.last_of_sample = last;
         v.last_of_run           = 1'b0;
         expected_values.push_back(v);
         k++;
         slot_cur++;
         if (last) begin
            sample_cur++;
            slot_cur  = 0;
            value_cur = 0;
            hap_cur   = 0;
            sum_acc   = '0;
         end
      end
      if (k > 0) begin
         v = expected_values.pop_back();
         v.last_of_run = 1'b1;
         expected_values.push_back(v);
      end
      if (flush && sample_cur >= cnt) clear_cursors();
   endtask

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic compare_result();
      unpacked_value_type e;
      if (expected_values.size() == 0) begin
         report("unexpected result", 32'd1, 32'd0);
         return;
      end
      e = expected_values.pop_front();
      if (rsp_channel.probability !== e.fields.probability)
         report("probability", rsp_channel.probability, e.fields.probability);
      if (rsp_channel.raw_value !== e.fields.raw_value)
         report("raw_value", rsp_channel.raw_value, e.fields.raw_value);
      if (rsp_channel.sample_index !== e.fields.sample_index)
         report("sample_index", 32'(rsp_channel.sample_index), 32'(e.fields.sample_index));
      if (rsp_channel.slot_index !== e.fields.slot_index)
         report("slot_index", 32'(rsp_channel.slot_index), 32'(e.fields.slot_index));
      if (rsp_channel.value_kind !== e.fields.value_kind)
         report("value_kind", 32'(rsp_channel.value_kind), 32'(e.fields.value_kind));
      if (rsp_channel.sum_overflow !== e.fields.sum_overflow)
         report("sum_overflow", 32'(rsp_channel.sum_overflow), 32'(e.fields.sum_overflow));
      if (rsp_channel.last_of_sample !== e.fields.last_of_sample)
         report("last_of_sample", 32'(rsp_channel.last_of_sample),
                32'(e.fields.last_of_sample));
      if (rsp_channel.last_of_run !== e.last_of_run)
         report("last_of_run", 32'(rsp_channel.last_of_run), 32'(e.last_of_run));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_bits    = 6'd8;
         cfg_alleles = 3'd2;
         cfg_phased  = 1'b0;
         cfg_plimit  = 3'd2;
         cfg_samples = 13'd1;
         clear_cursors();
         expected_values.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BITS_PER_VALUE: cfg_bits    = csr_write_data[5:0];
               CSR_ALLELE_COUNT:   cfg_alleles = csr_write_data[2:0];
               CSR_PHASED_MODE:    cfg_phased  = csr_write_data[0];
               CSR_PLOIDY_LIMIT:   cfg_plimit  = csr_write_data[2:0];
               CSR_SAMPLE_COUNT:   cfg_samples = csr_write_data[12:0];
               default: ;
            endcase
         end
         if (req_channel.valid && req_channel.ready)
            decode_request(req_channel.action, req_channel.byte_value);
         if (rsp_channel.valid && rsp_channel.ready) compare_result();
      end
      pending_count = expected_values.size();
   end

endmodule

[sim/genotype_probability_unpacker_core_tb.sv]
`timescale 1ns / 1ps

module genotype_probability_unpacker_core_tb;
   import gpunp_pkg::*;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int unsigned QUIET_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES = 700;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;
   int unsigned                error_count, pending_count;
   int unsigned                requests_sent = 0;
   int unsigned                quiet_cycles = 0;
   bit                         idling_on = 1'b1;
   bit                         hold_go = 1'b0;
   bit                         hold_done = 1'b0;

   gpunp_req_if req_channel();
   gpunp_rsp_if rsp_channel();

   genotype_probability_unpacker_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .rsp_channel      (rsp_channel)
   );

   genotype_probability_unpacker_core_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_channel      (req_channel),
      .rsp_channel      (rsp_channel),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_channel.valid && req_channel.ready) ||
             (rsp_channel.valid && rsp_channel.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** genotype_probability_unpacker_core: FAILED **");
            $finish;
         end
      end
   end

   // result side: random back-pressure plus one long hold-off
   initial begin
      rsp_channel.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            rsp_channel.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (400) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_channel.ready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_channel.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [7:0] b);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_channel.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_channel.valid      <= 1'b1;
      req_channel.action     <= act;
      req_channel.byte_value <= b;
      do @(posedge clock); while (!req_channel.ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic settle();
      req_channel.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // rewind via an empty variant, then load the new settings
   task automatic configure(input logic [5:0] bits, input logic [2:0] alleles,
                            input logic phased, input logic [2:0] plimit,
                            input logic [12:0] samples);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SAMPLE_COUNT;
      csr_write_data   <= '0;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      send_request(ACT_FLUSH, 8'($urandom));
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BITS_PER_VALUE;
      csr_write_data   <= 13'(bits);
      @(negedge clock);
      csr_index        <= CSR_ALLELE_COUNT;
      csr_write_data   <= 13'(alleles);
      @(negedge clock);
      csr_index        <= CSR_PHASED_MODE;
      csr_write_data   <= 13'(phased);
      @(negedge clock);
      csr_index        <= CSR_PLOIDY_LIMIT;
      csr_write_data   <= 13'(plimit);
      @(negedge clock);
      csr_index        <= CSR_SAMPLE_COUNT;
      csr_write_data   <= samples;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_variant();
      logic [5:0]  bits;
      logic [2:0]  alleles, plimit;
      logic        phased;
      int unsigned cnt, lim, nb, want, ndata, nflush, r;
      logic [7:0]  pbyte;
      r       = $urandom_range(0, 9);
      bits    = r == 0 ? 6'($urandom_range(0, 63)) : r == 1 ? 6'd32 : r == 2 ? 6'd1 :
                6'($urandom_range(1, 16));
      alleles = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(2, 4));
      plimit  = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(1, 4));
      phased  = 1'($urandom);
      cnt     = $urandom_range(0, 11) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 5);
      configure(bits, alleles, phased, plimit, 13'(cnt));
      lim = plimit < 1 ? 1 : (plimit > 4 ? 4 : plimit);
      nb  = bits == 0 ? 1 : (bits > 32 ? 32 : bits);
      for (int unsigned i = 0; i < cnt; i++) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            pbyte = {1'($urandom_range(0, 5) == 0), 7'($urandom_range(0, lim))};
         end else if (r < 8) begin
            pbyte = {1'b0, 7'($urandom_range(lim, 127))};
         end else begin
            pbyte = 8'($urandom);
         end
         send_request(ACT_PLOIDY, pbyte);
      end
      if ($urandom_range(0, 7) == 0) send_request(ACT_IGNORED, 8'($urandom));
      if (cnt > 0 && $urandom_range(0, 11) == 0) send_request(ACT_FLUSH, 8'($urandom));
      want  = (cnt * 6 * nb + 7) / 8;
      want  = want > 40 ? 40 : (want < 1 ? 1 : want);
      ndata = $urandom_range(1, want);
      for (int unsigned i = 0; i < ndata; i++) begin
         if ($urandom_range(0, 19) == 0) send_request(ACT_IGNORED, 8'($urandom));
         send_request(ACT_DATA, 8'($urandom));
      end
      nflush = (cnt * 35 + 63) / 64;
      if (nflush == 0) nflush = 1;
      repeat (nflush) send_request(ACT_FLUSH, 8'($urandom));
   endtask

   initial begin
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = '0;
      csr_write_data         = '0;
      req_channel.valid      = 1'b0;
      req_channel.action     = ACT_PLOIDY;
      req_channel.byte_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // saturated sum, missing sample, zero ploidy, ploidy above limit
      configure(6'd8, 3'd2, 1'b0, 3'd2, 13'd4);
      send_request(ACT_PLOIDY, 8'h02);
      send_request(ACT_PLOIDY, 8'h82);
      send_request(ACT_PLOIDY, 8'h00);
      send_request(ACT_PLOIDY, 8'h7F);
      send_request(ACT_DATA, 8'hFF);
      send_request(ACT_DATA, 8'hFF);
      send_request(ACT_IGNORED, 8'hFF);
      send_request(ACT_DATA, 8'h00);
      send_request(ACT_DATA, 8'h00);
      send_request(ACT_DATA, 8'hAA);
      send_request(ACT_DATA, 8'h55);
      send_request(ACT_FLUSH, 8'h00);

      // one-bit phased values, flush zero-fills the tail
      configure(6'd1, 3'd4, 1'b1, 3'd4, 13'd2);
      send_request(ACT_PLOIDY, 8'h04);
      send_request(ACT_PLOIDY, 8'h03);
      send_request(ACT_DATA, 8'h5A);
      send_request(ACT_FLUSH, 8'h00);

      configure(6'd32, 3'd3, 1'b0, 3'd3, 13'd1);
      send_request(ACT_PLOIDY, 8'h03);
      repeat (4) send_request(ACT_DATA, 8'hFF);
      send_request(ACT_FLUSH, 8'h00);

      // sample count beyond the table, only partly decoded
      configure(6'd32, 3'd2, 1'b0, 3'd2, 13'h1FFF);
      repeat (4) send_request(ACT_PLOIDY, 8'h02);
      repeat (12) send_request(ACT_DATA, 8'($urandom));

      configure(6'd63, 3'd7, 1'b0, 3'd7, 13'd1);
      send_request(ACT_PLOIDY, 8'h04);
      send_request(ACT_FLUSH, 8'h00);

      hold_go = 1'b1;
      while (requests_sent < 330) begin
         if (requests_sent > 280) idling_on = 1'b0;
         random_variant();
      end

      req_channel.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("** genotype_probability_unpacker_core: PASSED **");
      end else begin
         $display("** genotype_probability_unpacker_core: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/gpunp_pkg.sv
hw/rtl/gpunp_if.sv
hw/rtl/gpunp_ram.sv
hw/rtl/gpunp_frac.sv
hw/rtl/genotype_probability_unpacker_core.sv
sim/genotype_probability_unpacker_core_checker.sv
sim/genotype_probability_unpacker_core_tb.sv
